>>> sv/racc_pkg.sv
// Shared types and constants for the request and byte admission control core.
// No dependencies; every other file of the block but racc_if imports this package.
package racc_pkg;

	// Command codes as they arrive on the request channel.
	localparam logic [2:0] CMD_RESERVE = 3'd0;
	localparam logic [2:0] CMD_RELEASE = 3'd1;
	localparam logic [2:0] CMD_PREPARE = 3'd2;
	localparam logic [2:0] CMD_CLOSE   = 3'd3;
	localparam logic [2:0] CMD_QUERY   = 3'd4;

	// Configuration register indexes, taken from paddr[3].
	localparam logic REG_SLOT_CAPACITY = 1'b0;
	localparam logic REG_BYTE_LIMIT    = 1'b1;
	localparam int   APB_ADDR_W        = 4;
	localparam int   APB_DATA_W        = 64;

	localparam logic [15:0] SLOT_CAPACITY_RESET = 16'd64;
	localparam logic [63:0] BYTE_LIMIT_RESET    = 64'd268435456;

	// Accounted bytes are FIXED_BYTES plus eight times the encoded size.
	localparam logic [63:0] FIXED_BYTES = 64'd16777216;
	localparam int          EXPAND_SHIFT = 3;
	localparam logic [63:0] SIZE_LIMIT =
		(64'hFFFF_FFFF_FFFF_FFFF - FIXED_BYTES) >> EXPAND_SHIFT;

	localparam int QUEUE_DEPTH_DEFAULT = 2;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_CLOSING = 3'd1,
		ST_FULL    = 3'd2,
		ST_BUDGET  = 3'd3,
		ST_INVALID = 3'd4,
		ST_ACCOUNT = 3'd5
	} status_t;

	// Operations after classification; OP_REFUSE carries a status already settled.
	typedef enum logic [2:0] {
		OP_RESERVE,
		OP_RELEASE,
		OP_PREPARE,
		OP_CLOSE,
		OP_QUERY,
		OP_REFUSE
	} op_t;

	typedef struct packed {
		op_t         op;
		status_t     status;
		logic [63:0] gen;
		logic [63:0] amount;
		logic        holds_slot;
	} racc_item_t;

endpackage

>>> sv/racc_if.sv
// Valid/ready channel interfaces for requests and results of the admission core.
// Self-contained; used by the front end, the back end and the top level.
interface racc_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [63:0] client_gen;
	logic [63:0] encoded_size;
	logic [63:0] byte_amount;
	logic        holds_slot;

	modport source (
		output valid, cmd, client_gen, encoded_size, byte_amount, holds_slot,
		input  ready
	);
	modport sink (
		input  valid, cmd, client_gen, encoded_size, byte_amount, holds_slot,
		output ready
	);
endinterface

interface racc_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] charged_bytes;
	logic [15:0] active_slots;
	logic [63:0] active_byte_total;
	logic [15:0] slot_peak;
	logic [63:0] byte_peak;
	logic [63:0] slot_rejections;
	logic [63:0] byte_rejections;
	logic        is_closing;
	logic [63:0] current_generation;

	modport source (
		output valid, status, charged_bytes, active_slots, active_byte_total,
			slot_peak, byte_peak, slot_rejections, byte_rejections, is_closing,
			current_generation,
		input  ready
	);
	modport sink (
		input  valid, status, charged_bytes, active_slots, active_byte_total,
			slot_peak, byte_peak, slot_rejections, byte_rejections, is_closing,
			current_generation,
		output ready
	);
endinterface

>>> sv/racc_front.sv
// Front end: accepts requests, decodes the command and checks the encoded size.
// Depends on racc_pkg and racc_req_if; feeds racc_queue.
module racc_front (
	racc_req_if.sink           req,
	input  logic               fifo_full,
	output logic               push,
	output racc_pkg::racc_item_t push_item
);
	import racc_pkg::*;

	logic [63:0] size_scaled;

	assign req.ready = !fifo_full;
	assign push      = req.valid && !fifo_full;

	assign size_scaled = {req.encoded_size[63-EXPAND_SHIFT:0], {EXPAND_SHIFT{1'b0}}};

	always_comb begin
		push_item            = '0;
		push_item.op         = OP_QUERY;
		push_item.status     = ST_OK;
		push_item.gen        = req.client_gen;
		push_item.holds_slot = req.holds_slot;
		case (req.cmd)
			CMD_RESERVE: begin
				// Size faults are settled here; they never touch the counters.
				if (req.encoded_size == '0) begin
					push_item.op     = OP_REFUSE;
					push_item.status = ST_INVALID;
				end else if (req.encoded_size > SIZE_LIMIT) begin
					push_item.op     = OP_REFUSE;
					push_item.status = ST_BUDGET;
				end else begin
					push_item.op     = OP_RESERVE;
					push_item.amount = FIXED_BYTES + size_scaled;
				end
			end
			CMD_RELEASE: begin
				push_item.op     = OP_RELEASE;
				push_item.amount = req.byte_amount;
			end
			CMD_PREPARE: push_item.op = OP_PREPARE;
			CMD_CLOSE:   push_item.op = OP_CLOSE;
			default:     push_item.op = OP_QUERY;
		endcase
	end

endmodule

>>> sv/racc_queue.sv
// Short FIFO of classified requests between the front and back ends.
// Depends on racc_pkg for the entry type.
module racc_queue #(
	parameter int DEPTH = racc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  racc_pkg::racc_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output racc_pkg::racc_item_t pop_item
);
	import racc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	racc_item_t       entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/racc_back.sv
// Back end: holds the admission state, executes one request per cycle unless the
// result is stalled, and registers the result. Depends on racc_pkg and racc_rsp_if.
module racc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  racc_pkg::racc_item_t item,
	output logic                 pop,
	input  logic [15:0]          slot_capacity,
	input  logic [63:0]          byte_limit,
	racc_rsp_if.source           rsp
);
	import racc_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [63:0] charged;
		logic [15:0] slots;
		logic [63:0] bytes;
		logic [15:0] slot_peak;
		logic [63:0] byte_peak;
		logic [63:0] slot_rej;
		logic [63:0] byte_rej;
		logic        closing;
		logic [63:0] gen;
	} result_t;

	logic        closing_q, closing_n;
	logic [63:0] gen_q, gen_n;
	logic [15:0] slots_q, slots_n;
	logic [63:0] bytes_q, bytes_n;
	logic [15:0] slot_peak_q, slot_peak_n;
	logic [63:0] byte_peak_q, byte_peak_n;
	logic [63:0] slot_rej_q, slot_rej_n;
	logic [63:0] byte_rej_q, byte_rej_n;
	status_t     status_n;
	logic [63:0] charged_n;

	logic [64:0] byte_sum;
	logic [15:0] slots_inc;
	logic [63:0] gen_inc;

	logic        out_valid_q;
	result_t     result_q;

	// Only refill the result register when it is empty or being taken.
	assign pop = !empty && (!out_valid_q || rsp.ready);

	// Sum kept at 65 bits so the budget compare cannot wrap.
	assign byte_sum  = {1'b0, bytes_q} + {1'b0, item.amount};
	assign slots_inc = slots_q + 16'd1;
	assign gen_inc   = gen_q + 64'd1;

	always_comb begin
		closing_n   = closing_q;
		gen_n       = gen_q;
		slots_n     = slots_q;
		bytes_n     = bytes_q;
		slot_peak_n = slot_peak_q;
		byte_peak_n = byte_peak_q;
		slot_rej_n  = slot_rej_q;
		byte_rej_n  = byte_rej_q;
		status_n    = ST_OK;
		charged_n   = '0;
		case (item.op)
			OP_RESERVE: begin
				if (closing_q || (gen_q != item.gen)) begin
					status_n = ST_CLOSING;
				end else if (slots_q >= slot_capacity) begin
					status_n   = ST_FULL;
					slot_rej_n = slot_rej_q + 64'd1;
				end else if (byte_sum > {1'b0, byte_limit}) begin
					status_n   = ST_BUDGET;
					byte_rej_n = byte_rej_q + 64'd1;
				end else begin
					slots_n   = slots_inc;
					bytes_n   = byte_sum[63:0];
					charged_n = item.amount;
					if (slots_inc > slot_peak_q) begin
						slot_peak_n = slots_inc;
					end
					if (byte_sum[63:0] > byte_peak_q) begin
						byte_peak_n = byte_sum[63:0];
					end
				end
			end
			OP_REFUSE: status_n = item.status;
			OP_RELEASE: begin
				if ((item.holds_slot && (slots_q == '0)) || (bytes_q < item.amount)) begin
					status_n = ST_ACCOUNT;
				end else begin
					if (item.holds_slot) begin
						slots_n = slots_q - 16'd1;
					end
					bytes_n = bytes_q - item.amount;
				end
			end
			OP_PREPARE: begin
				if (slots_q == '0) begin
					status_n = ST_ACCOUNT;
				end else begin
					slots_n = slots_q - 16'd1;
				end
			end
			OP_CLOSE: begin
				// The generation skips zero when it wraps.
				if (!closing_q) begin
					closing_n = 1'b1;
					gen_n     = (gen_inc == '0) ? 64'd1 : gen_inc;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closing_q   <= 1'b0;
			gen_q       <= 64'd1;
			slots_q     <= '0;
			bytes_q     <= '0;
			slot_peak_q <= '0;
			byte_peak_q <= '0;
			slot_rej_q  <= '0;
			byte_rej_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				closing_q   <= closing_n;
				gen_q       <= gen_n;
				slots_q     <= slots_n;
				bytes_q     <= bytes_n;
				slot_peak_q <= slot_peak_n;
				byte_peak_q <= byte_peak_n;
				slot_rej_q  <= slot_rej_n;
				byte_rej_q  <= byte_rej_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.status    <= status_n;
			result_q.charged   <= charged_n;
			result_q.slots     <= slots_n;
			result_q.bytes     <= bytes_n;
			result_q.slot_peak <= slot_peak_n;
			result_q.byte_peak <= byte_peak_n;
			result_q.slot_rej  <= slot_rej_n;
			result_q.byte_rej  <= byte_rej_n;
			result_q.closing   <= closing_n;
			result_q.gen       <= closing_n ? '0 : gen_n;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.status             = result_q.status;
	assign rsp.charged_bytes      = result_q.charged;
	assign rsp.active_slots       = result_q.slots;
	assign rsp.active_byte_total  = result_q.bytes;
	assign rsp.slot_peak          = result_q.slot_peak;
	assign rsp.byte_peak          = result_q.byte_peak;
	assign rsp.slot_rejections    = result_q.slot_rej;
	assign rsp.byte_rejections    = result_q.byte_rej;
	assign rsp.is_closing         = result_q.closing;
	assign rsp.current_generation = result_q.gen;

endmodule

>>> sv/request_and_byte_admission_control_core.sv
// Admission controller with a request slot limit and a byte budget.
// An accepted request passes through the queue into the back end's result register.
// Throughput: one request per cycle while the result channel is not stalled.
// A two-entry queue and the result register let input and output stall independently.
// Reset (arst_n, asynchronous, active low) clears all counters, opens admission at
// generation 1 and loads slot_capacity = 64 and byte_limit = 268435456.
module request_and_byte_admission_control_core #(
	parameter int QUEUE_DEPTH = racc_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	racc_req_if.sink                        req,
	racc_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [racc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [racc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [racc_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import racc_pkg::*;

	logic        fifo_full;
	logic        queue_empty;
	logic        push;
	logic        pop;
	racc_item_t  push_item;
	racc_item_t  pop_item;
	logic [15:0] slot_capacity_q;
	logic [63:0] byte_limit_q;
	logic        reg_sel;

	// Registers sit eight bytes apart; the low address bits are ignored.
	assign reg_sel = paddr[APB_ADDR_W-1];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_capacity_q <= SLOT_CAPACITY_RESET;
			byte_limit_q    <= BYTE_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_SLOT_CAPACITY: slot_capacity_q <= pwdata[15:0];
				REG_BYTE_LIMIT:    byte_limit_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SLOT_CAPACITY: prdata = {48'd0, slot_capacity_q};
			REG_BYTE_LIMIT:    prdata = byte_limit_q;
			default:           prdata = '0;
		endcase
	end

	racc_front u_front (
		.req       (req),
		.fifo_full (fifo_full),
		.push      (push),
		.push_item (push_item)
	);

	racc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop       (pop),
		.empty     (queue_empty),
		.pop_item  (pop_item)
	);

	racc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (queue_empty),
		.item          (pop_item),
		.pop           (pop),
		.slot_capacity (slot_capacity_q),
		.byte_limit    (byte_limit_q),
		.rsp           (rsp)
	);

endmodule

>>> sv/racc_checker.sv
// Port-level checks for the admission core, attached to the top level by bind.
// Depends on racc_pkg; sees only the top-level request and result channels.
module racc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [63:0] rsp_charged_bytes,
	input logic [15:0] rsp_active_slots,
	input logic [15:0] rsp_slot_peak,
	input logic        rsp_is_closing,
	input logic [63:0] rsp_current_generation
);
	import racc_pkg::*;

	logic [7:0] pending_q;
	logic       seen_closing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= '0;
			seen_closing_q <= 1'b0;
		end else begin
			pending_q <= pending_q + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);
			if (rsp_valid && rsp_ready && rsp_is_closing) begin
				seen_closing_q <= 1'b1;
			end
		end
	end

	// Every result answers a request that was taken earlier.
	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pending_q != '0))
		else $error("result shown with no request outstanding");

	// Once a result has reported closing, all later results do too.
	a_closing_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && seen_closing_q) |-> rsp_is_closing)
		else $error("admission reopened after close");

	a_generation_view: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_is_closing == (rsp_current_generation == '0)))
		else $error("generation does not match closing state");

	// Slots only grow through reserves, which also lift the peak.
	a_slots_under_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_status != ST_OK)) |-> ((rsp_charged_bytes == '0)
			&& (rsp_active_slots <= rsp_slot_peak)))
		else $error("refused request charged bytes or slots exceed peak");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
			&& $stable(rsp_charged_bytes)))
		else $error("stalled result changed");

endmodule

bind request_and_byte_admission_control_core racc_checker u_racc_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.req_valid              (req.valid),
	.req_ready              (req.ready),
	.rsp_valid              (rsp.valid),
	.rsp_ready              (rsp.ready),
	.rsp_status             (rsp.status),
	.rsp_charged_bytes      (rsp.charged_bytes),
	.rsp_active_slots       (rsp.active_slots),
	.rsp_slot_peak          (rsp.slot_peak),
	.rsp_is_closing         (rsp.is_closing),
	.rsp_current_generation (rsp.current_generation)
);

>>> tb/request_and_byte_admission_control_core_test.sv
// Self-checking testbench for the request and byte admission control core.
// Depends on racc_pkg, the racc_req_if/racc_rsp_if channel interfaces and the core itself.
// Covers directed corner requests, then random phases over several limit settings.
module request_and_byte_admission_control_core_test;
	import racc_pkg::*;

	localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;
	localparam logic [63:0] ALL_ONES        = '1;
	localparam int          HOLD_CYCLES     = 60;
	localparam int          QUIET_LIMIT     = 2000;
	localparam int          SETTLE_CYCLES   = 4;
	localparam int          MAX_PRINTS      = 40;
	localparam int          LOOKAHEAD       = 4;

	typedef struct {
		logic [2:0]  cmd;
		logic [63:0] gen;
		logic [63:0] size;
		logic [63:0] amount;
		logic        holds;
	} command_t;

	typedef struct {
		status_t     status;
		logic [63:0] charged;
		logic [15:0] slots;
		logic [63:0] bytes;
		logic [15:0] slot_peak;
		logic [63:0] byte_peak;
		logic [63:0] slot_rej;
		logic [63:0] byte_rej;
		logic        closing;
		logic [63:0] generation;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata, prdata;

	racc_req_if req_ch ();
	racc_rsp_if rsp_ch ();

	request_and_byte_admission_control_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Limits and admission state as the core should hold them.
	logic [15:0] cap_copy;
	logic [63:0] budget_copy;
	logic        adm_closed;
	logic [63:0] adm_generation;
	logic [15:0] adm_slots;
	logic [63:0] adm_bytes;
	logic [15:0] adm_slot_peak;
	logic [63:0] adm_byte_peak;
	logic [63:0] adm_slot_rej;
	logic [63:0] adm_byte_rej;

	command_t    pending_cmds[$];
	outcome_t    expected_outcomes[$];
	logic [63:0] granted_charges[$];

	int errors = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int grants = 0;
	int refusals = 0;
	int settings_used = 1;
	bit idle_on = 1'b1;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int stall_left = 0;
	int gap_left = 0;
	int quiet_cycles = 0;
	logic [63:0] gen_hint;

	function automatic outcome_t admit(command_t c);
		outcome_t o;
		logic [63:0] acc;
		o.status = ST_OK;
		o.charged = '0;
		case (c.cmd)
			CMD_RESERVE: begin
				if (c.size == 0) begin
					o.status = ST_INVALID;
				end else if (c.size > SIZE_LIMIT) begin
					// Too large to account for at all: refused without counting.
					o.status = ST_BUDGET;
				end else begin
					acc = FIXED_BYTES + (c.size << EXPAND_SHIFT);
					if (adm_closed || c.gen != adm_generation) begin
						o.status = ST_CLOSING;
					end else if (adm_slots >= cap_copy) begin
						o.status = ST_FULL;
						adm_slot_rej++;
					end else if (acc > budget_copy || adm_bytes > budget_copy - acc) begin
						o.status = ST_BUDGET;
						adm_byte_rej++;
					end else begin
						adm_slots++;
						adm_bytes += acc;
						if (adm_slots > adm_slot_peak) adm_slot_peak = adm_slots;
						if (adm_bytes > adm_byte_peak) adm_byte_peak = adm_bytes;
						o.charged = acc;
					end
				end
			end
			CMD_RELEASE: begin
				if ((c.holds && adm_slots == 0) || adm_bytes < c.amount) begin
					o.status = ST_ACCOUNT;
				end else begin
					if (c.holds) adm_slots--;
					adm_bytes -= c.amount;
				end
			end
			CMD_PREPARE: begin
				if (adm_slots == 0) o.status = ST_ACCOUNT;
				else adm_slots--;
			end
			CMD_CLOSE: begin
				if (!adm_closed) begin
					adm_closed = 1'b1;
					adm_generation++;
					if (adm_generation == 0) adm_generation = 1;
				end
			end
			default: ;
		endcase
		o.slots = adm_slots;
		o.bytes = adm_bytes;
		o.slot_peak = adm_slot_peak;
		o.byte_peak = adm_byte_peak;
		o.slot_rej = adm_slot_rej;
		o.byte_rej = adm_byte_rej;
		o.closing = adm_closed;
		o.generation = adm_closed ? '0 : adm_generation;
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
				results_seen, name, got, want));
	endtask

	// Mostly no gap, sometimes a few cycles, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Request driver: predicts each request as it is accepted.
	always @(posedge clk) begin
		logic     next_valid;
		command_t c;
		outcome_t o;
		if (arst_n) begin
			next_valid = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				c.cmd = req_ch.cmd;
				c.gen = req_ch.client_gen;
				c.size = req_ch.encoded_size;
				c.amount = req_ch.byte_amount;
				c.holds = req_ch.holds_slot;
				o = admit(c);
				expected_outcomes.insert(expected_outcomes.size(), o);
				requests_sent++;
				if (c.cmd == CMD_RESERVE) begin
					if (o.status == ST_OK) begin
						grants++;
						granted_charges.insert(granted_charges.size(), o.charged);
					end else begin
						refusals++;
					end
				end
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0) begin
					c = pending_cmds.pop_front();
					req_ch.cmd <= c.cmd;
					req_ch.client_gen <= c.gen;
					req_ch.encoded_size <= c.size;
					req_ch.byte_amount <= c.amount;
					req_ch.holds_slot <= c.holds;
					next_valid = 1'b1;
					gap_left = idle_on ? gap_len() : 0;
				end
			end
			req_ch.valid <= next_valid;
		end
	end

	// Result monitor and receiver stalls.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (expected_outcomes.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no request waiting",
						results_seen));
				end else begin
					e = expected_outcomes.pop_front();
					check_field("status", 64'(rsp_ch.status), 64'(e.status));
					check_field("charged_bytes", rsp_ch.charged_bytes, e.charged);
					check_field("active_slots", 64'(rsp_ch.active_slots), 64'(e.slots));
					check_field("active_byte_total", rsp_ch.active_byte_total, e.bytes);
					check_field("slot_peak", 64'(rsp_ch.slot_peak), 64'(e.slot_peak));
					check_field("byte_peak", rsp_ch.byte_peak, e.byte_peak);
					check_field("slot_rejections", rsp_ch.slot_rejections, e.slot_rej);
					check_field("byte_rejections", rsp_ch.byte_rejections, e.byte_rej);
					check_field("is_closing", 64'(rsp_ch.is_closing), 64'(e.closing));
					check_field("current_generation", rsp_ch.current_generation,
						e.generation);
				end
			end
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
				$display("** request_and_byte_admission_control_core: FAILED **");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic idx, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_SLOT_CAPACITY) cap_copy = value[15:0];
		else budget_copy = value;
	endtask

	task automatic push(input logic [2:0] cmd, input logic [63:0] gen,
			input logic [63:0] size, input logic [63:0] amount, input logic holds);
		command_t c;
		c.cmd = cmd;
		c.gen = gen;
		c.size = size;
		c.amount = amount;
		c.holds = holds;
		while (pending_cmds.size() >= LOOKAHEAD) @(negedge clk);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || req_ch.valid || expected_outcomes.size() != 0);
	endtask

	function automatic logic [63:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 64'($urandom_range(1, 1 << 20));
		if (r < 75) return 64'($urandom_range(1, 1 << 25));
		if (r < 85) return SIZE_LIMIT - 64'($urandom_range(0, 3));
		if (r < 91) return SIZE_LIMIT + 64'($urandom_range(1, 3));
		if (r < 95) return '0;
		return rand64();
	endfunction

	// Mostly well-formed reserve/release traffic, with some noise mixed in.
	task automatic push_random(input int close_pct);
		int          r;
		logic [2:0]  cmd;
		logic [63:0] amount;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < close_pct) begin
			push(CMD_CLOSE, rand64(), rand64(), rand64(), 1'($urandom));
			gen_hint = 64'd2;
		end else if (r < 15) begin
			cmd = 3'($urandom_range(0, 7));
			if (cmd == CMD_CLOSE && close_pct == 0) cmd = CMD_QUERY;
			push(cmd, rand64(), rand64(), rand64(), 1'($urandom));
		end else if (r < 20) begin
			push(CMD_QUERY, rand64(), rand64(), rand64(), 1'($urandom));
		end else if (r < 48 && granted_charges.size() > 0) begin
			amount = granted_charges.pop_front();
			if ($urandom_range(0, 3) == 0) begin
				push(CMD_RELEASE, rand64(), rand64(), amount, 1'b0);
				push(CMD_PREPARE, rand64(), rand64(), rand64(), 1'($urandom));
			end else begin
				push(CMD_RELEASE, rand64(), rand64(), amount, 1'b1);
			end
		end else begin
			push(CMD_RESERVE, ($urandom_range(0, 9) == 0) ? rand64() : gen_hint,
				pick_size(), rand64(), 1'($urandom));
		end
	endtask

	task automatic run_phase(input logic [15:0] cap, input logic [63:0] budget,
			input int count, input bit gaps, input bit long_hold, input int close_pct);
		reg_write(REG_SLOT_CAPACITY, 64'(cap));
		reg_write(REG_BYTE_LIMIT, budget);
		settings_used++;
		idle_on = gaps;
		if (long_hold) hold_requests++;
		for (int i = 0; i < count; i++) push_random(close_pct);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_QUERY;
		req_ch.client_gen = '0;
		req_ch.encoded_size = '0;
		req_ch.byte_amount = '0;
		req_ch.holds_slot = 1'b0;
		rsp_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cap_copy = SLOT_CAPACITY_RESET;
		budget_copy = BYTE_LIMIT_RESET;
		adm_closed = 1'b0;
		adm_generation = 64'd1;
		adm_slots = '0;
		adm_bytes = '0;
		adm_slot_peak = '0;
		adm_byte_peak = '0;
		adm_slot_rej = '0;
		adm_byte_rej = '0;
		gen_hint = 64'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests against the reset limits.
		push(CMD_QUERY, '0, '0, '0, 1'b0);
		push(CMD_RESERVE, 64'd1, '0, '0, 1'b0);
		push(CMD_RESERVE, 64'd1, SIZE_LIMIT + 64'd1, '0, 1'b0);
		push(CMD_RESERVE, 64'd1, ALL_ONES, ALL_ONES, 1'b1);
		push(CMD_RESERVE, '0, 64'd1, '0, 1'b0);
		push(CMD_RESERVE, ALL_ONES, 64'd1, '0, 1'b0);
		push(CMD_RESERVE, 64'd1, 64'd1, '0, 1'b0);
		push(CMD_RESERVE, 64'd1, 64'd1 << 24, '0, 1'b0);
		push(CMD_RESERVE, 64'd1, 64'd1 << 24, '0, 1'b0);
		push(CMD_RESERVE, 64'd1, SIZE_LIMIT, '0, 1'b0);
		push(CMD_RELEASE, '0, '0, ALL_ONES, 1'b1);
		push(CMD_RELEASE, '0, '0, 64'd8, 1'b0);
		push(CMD_PREPARE, '0, '0, '0, 1'b0);
		push(CMD_PREPARE, '0, '0, '0, 1'b0);
		push(CMD_PREPARE, '0, '0, '0, 1'b1);
		push(CMD_RELEASE, '0, '0, '0, 1'b1);
		push(CMD_RELEASE, '0, '0, '0, 1'b0);
		// Returns everything still held by the two granted reserves.
		push(CMD_RELEASE, '0, '0, 64'd167772160, 1'b0);
		for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
			push(3'(c), ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
		wait_drained();

		run_phase(16'hFFFF, ALL_ONES, 150, 1'b1, 1'b0, 0);
		run_phase(16'd0, ALL_ONES, 40, 1'b0, 1'b1, 0);
		run_phase(16'd4, 64'd100000000, 120, 1'b1, 1'b0, 0);
		run_phase(16'hFFFF, '0, 40, 1'b1, 1'b0, 0);
		run_phase(16'($urandom_range(1, 32)), 64'($urandom_range(1 << 26, 32'h7FFF_FFFF)),
			150, 1'b1, 1'b1, 0);
		// Admission may be closed somewhere in this phase and then never reopens.
		run_phase(SLOT_CAPACITY_RESET, BYTE_LIMIT_RESET, 100, 1'b1, 1'b0, 4);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_outcomes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
		$display("Checked %0d results for %0d requests over %0d limit settings.",
			results_seen, requests_sent, settings_used);
		$display("Reserves granted: %0d, refused: %0d; admission closed at the end: %0b.",
			grants, refusals, adm_closed);
		if (errors == 0) begin
			$display("** request_and_byte_admission_control_core: PASSED **");
		end else begin
			$display("** request_and_byte_admission_control_core: FAILED **");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/racc_pkg.sv
sv/racc_if.sv
sv/racc_front.sv
sv/racc_queue.sv
sv/racc_back.sv
sv/request_and_byte_admission_control_core.sv
sv/racc_checker.sv
tb/request_and_byte_admission_control_core_test.sv
